// ===== hw/rtl/wfd_pkg.sv =====
`timescale 1ns / 1ps

package wfd_pkg;

    localparam int WORDS  = 256;
    localparam int WLEN   = 32;
    localparam int IDX_W  = $clog2(WORDS);
    localparam int POS_W  = $clog2(WLEN);
    localparam int LEN_W  = $clog2(WLEN + 1);
    localparam int USED_W = $clog2(WORDS + 1);
    localparam int CHR_AW = IDX_W + POS_W;
    localparam int CNT_W  = 16;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    function automatic logic is_delim(input logic [7:0] b);
        return b == 8'd9 || b == 8'd10 || b == 8'd13 || b == 8'd32 || b == 8'd40 ||
               b == 8'd41 || b == 8'd44 || b == 8'd46 || b == 8'd59;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
    endfunction

endpackage

// ===== hw/rtl/wfd_ram.sv =====
`timescale 1ns / 1ps

module wfd_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== hw/rtl/word_frequency_dictionary_top.sv =====
`timescale 1ns / 1ps

// Word frequency dictionary. Text bytes arrive on the input channel one item
// at a time; delimiters end a word, which is then counted or inserted in
// ascending byte order. A read item returns one character of a sorted entry,
// its count, the number of entries and the overflow flag on the output channel.
// A text byte inside a word is stored in the pending word from the idle state. A
// word end walks the sorted list one entry at a time, comparing one character
// per cycle through the character memory, then shifts the order memory entry by
// entry and copies the word one byte per cycle.
// A read passes S_RD1 and S_RD2 before its result is registered; an entry index
// past the last entry gives a zero result at once. Clear empties the table.
// After reset the table and the pending word are empty and the overflow flag is
// clear; the memories need no clearing pass. The result register holds one item;
// while the receiver stalls it, the block stalls every further item, as it does
// while it is busy with a word end or a read.
module word_frequency_dictionary_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_op,
    input  logic [7:0]                i_text_byte,
    input  logic [7:0]                i_entry_index,
    input  logic [4:0]                i_char_pos,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_word_char,
    output logic [15:0]               o_word_count,
    output logic [8:0]                o_entry_total,
    output logic                      o_overflow
);
    import wfd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ENT, S_SLOT, S_CMP, S_INC, S_INS, S_SH, S_SH2, S_CPY, S_RD1, S_RD2
    } t_state;

    t_state              r_state;
    logic [USED_W-1:0]   r_used;
    logic [LEN_W-1:0]    r_plen;
    logic                r_ovf;
    logic                r_out_valid;
    logic [7:0]          r_pend [WLEN];
    logic [USED_W-1:0]   r_pos;
    logic [USED_W-1:0]   r_k;
    logic [IDX_W-1:0]    r_slot;
    logic [LEN_W-1:0]    r_ci;
    logic [POS_W-1:0]    r_cpos;
    logic [7:0]          r_char;
    logic [CNT_W-1:0]    r_cnt;

    logic                in_acc;
    logic [7:0]          pend_rd;
    logic [LEN_W-1:0]    n_min;
    logic                ci_lt;
    logic [USED_W-1:0]   k_m1;

    logic                ord_we, ord_re, len_we, len_re, cnt_we, cnt_re, chr_we, chr_re;
    logic [IDX_W-1:0]    ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic [IDX_W-1:0]    len_raddr, cnt_waddr, cnt_raddr;
    logic [LEN_W-1:0]    len_rdata;
    logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
    logic [CHR_AW-1:0]   chr_waddr, chr_raddr;
    logic [7:0]          chr_rdata;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign pend_rd    = r_pend[r_ci[POS_W-1:0]];
    assign n_min      = (r_plen < len_rdata) ? r_plen : len_rdata;
    assign ci_lt      = r_ci < n_min;
    assign k_m1       = r_k - USED_W'(1);

    assign o_out_valid   = r_out_valid;
    assign o_word_char   = r_char;
    assign o_word_count  = r_cnt;
    assign o_entry_total = r_used;
    assign o_overflow    = r_ovf;

    always_comb begin
        ord_we = 1'b0; ord_waddr = r_pos[IDX_W-1:0]; ord_wdata = r_used[IDX_W-1:0];
        ord_re = 1'b0; ord_raddr = r_pos[IDX_W-1:0];
        len_we = 1'b0; len_re = 1'b0; len_raddr = ord_rdata;
        cnt_we = 1'b0; cnt_waddr = r_slot; cnt_wdata = CNT_W'(1);
        cnt_re = 1'b0; cnt_raddr = ord_rdata;
        chr_we = 1'b0; chr_waddr = {r_used[IDX_W-1:0], r_ci[POS_W-1:0]};
        chr_re = 1'b0; chr_raddr = {ord_rdata, {POS_W{1'b0}}};
        case (r_state)
            S_IDLE: begin
                ord_re    = in_acc && i_op == OP_READ;
                ord_raddr = i_entry_index[IDX_W-1:0];
            end
            S_ENT: begin
                ord_re = r_pos != r_used;
            end
            S_SLOT: begin
                len_re = 1'b1;
                chr_re = 1'b1;
            end
            S_CMP: begin
                chr_re    = ci_lt && pend_rd == chr_rdata;
                chr_raddr = {r_slot, r_ci[POS_W-1:0] + POS_W'(1)};
                cnt_re    = !ci_lt && r_plen == len_rdata;
                cnt_raddr = r_slot;
            end
            S_INC: begin
                cnt_we    = 1'b1;
                cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + CNT_W'(1);
            end
            S_INS: begin
                len_we    = r_used != USED_W'(WORDS);
                cnt_we    = r_used != USED_W'(WORDS);
                cnt_waddr = r_used[IDX_W-1:0];
            end
            S_SH: begin
                ord_we    = r_k == r_pos;
                ord_re    = r_k != r_pos;
                ord_raddr = k_m1[IDX_W-1:0];
            end
            S_SH2: begin
                ord_we    = 1'b1;
                ord_waddr = r_k[IDX_W-1:0];
                ord_wdata = ord_rdata;
            end
            S_CPY: begin
                chr_we = r_ci != r_plen;
            end
            S_RD1: begin
                len_re    = 1'b1;
                cnt_re    = 1'b1;
                chr_re    = 1'b1;
                chr_raddr = {ord_rdata, r_cpos};
            end
            default: begin
            end
        endcase
    end

    wfd_ram #(.P_WIDTH(IDX_W), .P_DEPTH(WORDS)) u_order (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_re(ord_re), .i_raddr(ord_raddr), .o_rdata(ord_rdata)
    );

    wfd_ram #(.P_WIDTH(LEN_W), .P_DEPTH(WORDS)) u_len (
        .i_clk(i_clk), .i_we(len_we), .i_waddr(r_used[IDX_W-1:0]), .i_wdata(r_plen),
        .i_re(len_re), .i_raddr(len_raddr), .o_rdata(len_rdata)
    );

    wfd_ram #(.P_WIDTH(CNT_W), .P_DEPTH(WORDS)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_re(cnt_re), .i_raddr(cnt_raddr), .o_rdata(cnt_rdata)
    );

    wfd_ram #(.P_WIDTH(8), .P_DEPTH(WORDS * WLEN)) u_chr (
        .i_clk(i_clk), .i_we(chr_we), .i_waddr(chr_waddr), .i_wdata(pend_rd),
        .i_re(chr_re), .i_raddr(chr_raddr), .o_rdata(chr_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_plen      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !(in_acc && i_op == OP_READ)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_op)
                            OP_BYTE: begin
                                if (is_delim(i_text_byte)) begin
                                    r_pos <= '0;
                                    if (r_plen != '0) begin
                                        r_state <= S_ENT;
                                    end
                                end else if (r_plen < LEN_W'(WLEN)) begin
                                    r_pend[r_plen[POS_W-1:0]] <= to_lower(i_text_byte);
                                    r_plen <= r_plen + LEN_W'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            OP_END: begin
                                r_pos <= '0;
                                if (r_plen != '0) begin
                                    r_state <= S_ENT;
                                end
                            end
                            OP_READ: begin
                                r_cpos <= i_char_pos[POS_W-1:0];
                                if ({1'b0, i_entry_index} < USED_W'(r_used)) begin
                                    r_out_valid <= 1'b0;
                                    r_state     <= S_RD1;
                                end else begin
                                    r_char      <= '0;
                                    r_cnt       <= '0;
                                    r_out_valid <= 1'b1;
                                end
                            end
                            OP_CLEAR: begin
                                r_used <= '0;
                                r_plen <= '0;
                                r_ovf  <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ENT: begin
                    r_state <= (r_pos == r_used) ? S_INS : S_SLOT;
                end
                S_SLOT: begin
                    r_slot  <= ord_rdata;
                    r_ci    <= '0;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (ci_lt) begin
                        if (pend_rd != chr_rdata) begin
                            if (pend_rd < chr_rdata) begin
                                r_state <= S_INS;
                            end else begin
                                r_pos   <= r_pos + USED_W'(1);
                                r_state <= S_ENT;
                            end
                        end else begin
                            r_ci <= r_ci + LEN_W'(1);
                        end
                    end else if (r_plen == len_rdata) begin
                        r_state <= S_INC;
                    end else if (r_plen < len_rdata) begin
                        r_state <= S_INS;
                    end else begin
                        r_pos   <= r_pos + USED_W'(1);
                        r_state <= S_ENT;
                    end
                end
                S_INC: begin
                    r_plen  <= '0;
                    r_state <= S_IDLE;
                end
                S_INS: begin
                    if (r_used == USED_W'(WORDS)) begin
                        r_ovf   <= 1'b1;
                        r_plen  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_used;
                        r_state <= S_SH;
                    end
                end
                S_SH: begin
                    if (r_k == r_pos) begin
                        r_ci    <= '0;
                        r_state <= S_CPY;
                    end else begin
                        r_state <= S_SH2;
                    end
                end
                S_SH2: begin
                    r_k     <= k_m1;
                    r_state <= S_SH;
                end
                S_CPY: begin
                    if (r_ci == r_plen) begin
                        r_used  <= r_used + USED_W'(1);
                        r_plen  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_ci <= r_ci + LEN_W'(1);
                    end
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_char      <= (LEN_W'(r_cpos) < len_rdata) ? chr_rdata : 8'd0;
                    r_cnt       <= cnt_rdata;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/wfd_checker.sv =====
`timescale 1ns / 1ps

module wfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_op,
    input logic [7:0]  i_text_byte,
    input logic [7:0]  i_entry_index,
    input logic [4:0]  i_char_pos,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_word_char,
    input logic [15:0] o_word_count,
    input logic [8:0]  o_entry_total,
    input logic        o_overflow
);
    import wfd_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_word_char)
            && $stable(o_word_count))
        else $error("result changed while stalled");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_total <= 9'(WORDS))
        else $error("entry total above table size");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_entry_total == 9'd0 |-> o_word_count == 16'd0 && o_word_char == 8'd0)
        else $error("read of empty table returned data");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_word_count == 16'd0 |-> o_word_char == 8'd0)
        else $error("character returned for missing entry");

endmodule

bind word_frequency_dictionary_top wfd_checker u_wfd_checker (.*);
